/* rtl/acc_pkg.sv */
// Package for the appliance countdown controller: shared types, constants and tables.
// Used by every module of the block; it depends on nothing else.
`default_nettype none
package acc_pkg;

    // Default values of the configuration registers.
    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd25;
    localparam logic [9:0]  TPS_RESET        = 10'd1000;
    localparam logic [9:0]  BEEP_RESET       = 10'd250;
    localparam logic [9:0]  NOTE_RESET       = 10'd250;
    localparam logic [7:0]  NOTICE_RESET     = 8'd100;
    localparam logic [15:0] INIT_TIMES_RESET = 16'd37749;

    localparam int NOTE_COUNT_DEFAULT = 3;

    // Register indexes on the write port.
    localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] REG_TPS        = 3'd1;
    localparam logic [2:0] REG_BEEP       = 3'd2;
    localparam logic [2:0] REG_NOTE       = 3'd3;
    localparam logic [2:0] REG_NOTICE     = 3'd4;
    localparam logic [2:0] REG_INIT_TIMES = 3'd5;

    // Machine state codes as they appear on the output.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_PAUSE = 2'd2;

    // Serial command codes.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_POWER = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Tone periods.
    localparam logic [7:0] TONE_START = 8'd255;
    localparam logic [7:0] TONE_STOP  = 8'd155;
    localparam logic [7:0] TONE_POWER = 8'd195;

    localparam int QUEUE_DEPTH = 2;

    // Jingle note periods; the fourth note repeats the third.
    function automatic logic [7:0] note_period(input logic [1:0] n);
        logic [7:0] p;
        case (n)
            2'd0:    p = 8'd220;
            2'd1:    p = 8'd180;
            default: p = 8'd150;
        endcase
        return p;
    endfunction

    // Configuration registers as one bundle.
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [9:0]  ticks_per_second;
        logic [9:0]  beep_ticks;
        logic [9:0]  note_ticks;
        logic [7:0]  notice_ticks;
        logic [15:0] initial_times;
    } t_cfg;

    // One classified tick handed from the front part to the back part.
    typedef struct packed {
        logic       start_level;
        logic       stop_level;
        logic [1:0] mode_switches;
        logic       power_press;
        logic [1:0] serial_command;
    } t_tick;

    // One result word.
    typedef struct packed {
        logic [1:0] oven_state;
        logic [3:0] seconds_left;
        logic [1:0] mode_index;
        logic [1:0] power_setting;
        logic [2:0] power_leds;
        logic       buzzer_on;
        logic [7:0] buzzer_period;
        logic       notice_led;
    } t_result;

endpackage
`default_nettype wire

/* rtl/appliance_countdown_controller_top.sv */
// Top level of the appliance countdown controller: registers, queue and tick engine.
// Depends on acc_pkg, acc_front and acc_back.
`default_nettype none
// Each input word is one millisecond tick and gives exactly one result word.
// Words pass through a two-entry queue into the tick engine, which handles one
// word per clock and holds its result in an output register; a new word is
// taken every cycle while the output side keeps up. A word is registered in the
// queue, then its result in the output register; the engine's update sets the
// throughput. Configuration must be written only while idle; no check enforces it.
module appliance_countdown_controller_top #(
    parameter int NOTE_COUNT = acc_pkg::NOTE_COUNT_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_start_level,
    input  wire logic        i_stop_level,
    input  wire logic [1:0]  i_mode_switches,
    input  wire logic        i_power_press,
    input  wire logic [1:0]  i_serial_command,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_oven_state,
    output logic [3:0]       o_seconds_left,
    output logic [1:0]       o_mode_index,
    output logic [1:0]       o_power_setting,
    output logic [2:0]       o_power_leds,
    output logic             o_buzzer_on,
    output logic [7:0]       o_buzzer_period,
    output logic             o_notice_led
);
    acc_pkg::t_cfg    r_cfg;
    acc_pkg::t_tick   in_tick, q_tick;
    acc_pkg::t_result res;
    logic             q_valid, q_take;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= acc_pkg::DEBOUNCE_RESET;
            r_cfg.ticks_per_second <= acc_pkg::TPS_RESET;
            r_cfg.beep_ticks       <= acc_pkg::BEEP_RESET;
            r_cfg.note_ticks       <= acc_pkg::NOTE_RESET;
            r_cfg.notice_ticks     <= acc_pkg::NOTICE_RESET;
            r_cfg.initial_times    <= acc_pkg::INIT_TIMES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                acc_pkg::REG_DEBOUNCE:   r_cfg.debounce_ticks   <= i_cfg_data[7:0];
                acc_pkg::REG_TPS:        r_cfg.ticks_per_second <= i_cfg_data[9:0];
                acc_pkg::REG_BEEP:       r_cfg.beep_ticks       <= i_cfg_data[9:0];
                acc_pkg::REG_NOTE:       r_cfg.note_ticks       <= i_cfg_data[9:0];
                acc_pkg::REG_NOTICE:     r_cfg.notice_ticks     <= i_cfg_data[7:0];
                acc_pkg::REG_INIT_TIMES: r_cfg.initial_times    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_tick = '{start_level: i_start_level, stop_level: i_stop_level,
                       mode_switches: i_mode_switches, power_press: i_power_press,
                       serial_command: i_serial_command};

    acc_front #(.DEPTH(acc_pkg::QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_tick(in_tick), .o_valid(q_valid), .i_take(q_take), .o_tick(q_tick)
    );

    acc_back #(.NOTE_COUNT(NOTE_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(q_valid),
        .o_take(q_take), .i_tick(q_tick), .o_valid(o_valid), .i_stall(i_stall),
        .o_result(res)
    );

    assign o_oven_state    = res.oven_state;
    assign o_seconds_left  = res.seconds_left;
    assign o_mode_index    = res.mode_index;
    assign o_power_setting = res.power_setting;
    assign o_power_leds    = res.power_leds;
    assign o_buzzer_on     = res.buzzer_on;
    assign o_buzzer_period = res.buzzer_period;
    assign o_notice_led    = res.notice_led;
endmodule
`default_nettype wire

/* rtl/acc_front.sv */
// Front part: accepts tick words into a short queue for the back part.
// Depends on acc_pkg.
`default_nettype none
module acc_front #(
    parameter int DEPTH = acc_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire acc_pkg::t_tick i_tick,
    output logic                o_valid,
    input  wire logic           i_take,
    output acc_pkg::t_tick      o_tick
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    acc_pkg::t_tick r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    // The queue is full only when every slot holds a word.
    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && i_take;
    assign o_tick  = r_mem[r_rd];

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_tick;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/acc_back.sv */
// Back part: debouncing, timers, jingle and the idle/running/paused machine.
// Depends on acc_pkg; takes one tick word per cycle from the queue while its output register is free.
`default_nettype none
module acc_back #(
    parameter int NOTE_COUNT = acc_pkg::NOTE_COUNT_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire acc_pkg::t_cfg    i_cfg,
    input  wire logic             i_valid,
    output logic                  o_take,
    input  wire acc_pkg::t_tick   i_tick,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output acc_pkg::t_result      o_result
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_PAUSE = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_cd, n_cd;
    logic [1:0]  r_mode, n_mode, r_pwr, n_pwr, r_last, n_last;
    logic [9:0]  r_tick, n_tick, r_beep, n_beep, r_notec, n_notec;
    logic        r_sec, n_sec, r_bdue, n_bdue, r_ton, n_ton;
    logic [7:0]  r_per, n_per;
    logic        r_jact, n_jact, r_jdone, n_jdone;
    logic [1:0]  r_nnum, n_nnum;
    logic        r_nlit, n_nlit;
    logic [7:0]  r_ncnt, n_ncnt;
    logic [1:0]  r_cand, n_cand, r_rep, n_rep;
    logic [7:0]  r_stab [2];
    logic [7:0]  n_stab [2];
    logic        r_spend, n_spend, r_ppend, n_ppend;
    logic        r_ov;
    acc_pkg::t_result r_res, n_res;
    logic        step;

    // Output register is free when empty or being taken.
    assign o_take   = !r_ov || !i_stall;
    assign step     = i_valid && o_take;
    assign o_valid  = r_ov;
    assign o_result = r_res;

    // One tick of the controller, in the order power, serial, debounce, timers, machine.
    always_comb begin
        logic [3:0] st;
        logic [1:0] lv;
        logic       rel;
        n_state = r_state; n_cd = r_cd; n_mode = r_mode; n_pwr = r_pwr;
        n_last = r_last; n_tick = r_tick; n_beep = r_beep; n_notec = r_notec;
        n_sec = r_sec; n_bdue = r_bdue; n_ton = r_ton; n_per = r_per;
        n_jact = r_jact; n_jdone = r_jdone; n_nnum = r_nnum; n_nlit = r_nlit;
        n_ncnt = r_ncnt; n_cand = r_cand; n_rep = r_rep; n_stab = r_stab;
        n_spend = r_spend; n_ppend = r_ppend;
        st = '0;
        lv = {i_tick.stop_level, i_tick.start_level};

        // Power button.
        if (i_tick.power_press) begin
            n_pwr = (n_pwr >= 2'd2) ? 2'd0 : n_pwr + 2'd1;
            if (n_jact) begin
                n_jact = 1'b0; n_nnum = '0; n_notec = '0;
            end
            n_ton = 1'b1; n_per = acc_pkg::TONE_POWER; n_bdue = 1'b0; n_beep = '0;
        end

        // Serial command decode.
        unique case (i_tick.serial_command)
            acc_pkg::CMD_POWER: begin
                n_pwr = (n_pwr >= 2'd2) ? 2'd0 : n_pwr + 2'd1;
                n_ton = 1'b1; n_per = acc_pkg::TONE_POWER; n_bdue = 1'b0; n_beep = '0;
            end
            acc_pkg::CMD_START: begin
                n_spend = 1'b1;
                n_ton = 1'b1; n_per = acc_pkg::TONE_START; n_bdue = 1'b0; n_beep = '0;
            end
            acc_pkg::CMD_STOP: begin
                n_ppend = 1'b1;
                n_ton = 1'b1; n_per = acc_pkg::TONE_STOP; n_bdue = 1'b0; n_beep = '0;
            end
            default: begin
            end
        endcase
        if (i_tick.serial_command != acc_pkg::CMD_NONE) begin
            n_nlit = 1'b1;
        end

        // Debounce both buttons; a release sets the pending action.
        for (int b = 0; b < 2; b++) begin
            rel = 1'b0;
            if (lv[b] == n_cand[b]) begin
                if (n_stab[b] != 8'hFF) n_stab[b] = n_stab[b] + 8'd1;
            end else begin
                n_stab[b] = '0; n_cand[b] = lv[b];
            end
            if (n_stab[b] >= i_cfg.debounce_ticks) begin
                rel = n_rep[b] && !n_cand[b];
                n_rep[b] = n_cand[b];
            end
            if (rel && b == 0) n_spend = 1'b1;
            if (rel && b == 1) n_ppend = 1'b1;
        end

        // Free-running counters.
        n_tick = n_tick + 10'd1;
        n_beep = n_beep + 10'd1;
        if (n_nlit) n_ncnt = n_ncnt + 8'd1;
        if (n_jact) begin
            n_notec = n_notec + 10'd1;
            if (n_notec >= i_cfg.note_ticks) begin
                n_nnum = n_nnum + 2'd1;
                n_notec = '0;
                if (32'(n_nnum) >= NOTE_COUNT || n_nnum == 2'd0) begin
                    n_jact = 1'b0; n_nnum = '0; n_ton = 1'b0;
                end else begin
                    n_per = acc_pkg::note_period(n_nnum);
                end
            end
        end
        if (n_tick >= i_cfg.ticks_per_second) begin
            n_sec = 1'b1; n_tick = '0;
        end
        if (n_beep >= i_cfg.beep_ticks) begin
            n_bdue = 1'b1; n_beep = '0;
        end
        if (n_nlit && n_ncnt >= i_cfg.notice_ticks) begin
            n_nlit = 1'b0; n_ncnt = '0;
        end

        // Key beep ends unless the jingle holds the tone.
        if (n_bdue && !n_jact && r_state != S_IDLE) begin
            n_bdue = 1'b0; n_beep = '0; n_ton = 1'b0;
        end

        // State machine.
        unique case (r_state)
            S_RUN: begin
                if (n_sec) begin
                    n_sec = 1'b0;
                    if (n_cd != 4'd0) begin
                        n_cd = n_cd - 4'd1;
                    end else begin
                        if (!n_jdone && !n_jact) begin
                            n_bdue = 1'b0; n_beep = '0; n_jact = 1'b1; n_nnum = '0;
                            n_notec = '0; n_ton = 1'b1;
                            n_per = acc_pkg::note_period(2'd0); n_jdone = 1'b1;
                        end
                        if (i_tick.mode_switches != n_last) begin
                            n_last = i_tick.mode_switches;
                            n_state = S_IDLE;
                            if (n_jact) begin
                                n_jact = 1'b0; n_nnum = '0; n_notec = '0; n_ton = 1'b0;
                            end
                        end
                    end
                end
                if (n_spend) begin
                    n_spend = 1'b0;
                    if (n_jact) begin
                        n_jact = 1'b0; n_nnum = '0; n_notec = '0;
                    end
                    n_tick = '0;
                    n_ton = 1'b1; n_per = acc_pkg::TONE_START; n_bdue = 1'b0; n_beep = '0;
                    n_cd = (n_cd < 4'd9) ? n_cd + 4'd1 : 4'd9;
                end
                if (n_ppend) begin
                    n_ppend = 1'b0;
                    if (n_jact) begin
                        n_jact = 1'b0; n_nnum = '0; n_notec = '0;
                    end
                    n_tick = '0;
                    n_ton = 1'b1; n_per = acc_pkg::TONE_STOP; n_bdue = 1'b0; n_beep = '0;
                    n_state = (n_cd == 4'd0) ? S_IDLE : S_PAUSE;
                end
            end
            S_PAUSE: begin
                if (n_ppend) begin
                    n_ppend = 1'b0;
                    if (n_jact) begin
                        n_jact = 1'b0; n_nnum = '0; n_notec = '0;
                    end
                    n_tick = '0;
                    n_ton = 1'b1; n_per = acc_pkg::TONE_STOP; n_bdue = 1'b0; n_beep = '0;
                    n_state = S_IDLE;
                end
                if (n_spend) begin
                    n_spend = 1'b0;
                    if (n_jact) begin
                        n_jact = 1'b0; n_nnum = '0; n_notec = '0;
                    end
                    n_tick = '0;
                    n_ton = 1'b1; n_per = acc_pkg::TONE_START; n_bdue = 1'b0; n_beep = '0;
                    n_state = S_RUN;
                end
            end
            default: begin
                n_mode = i_tick.mode_switches;
                st = i_cfg.initial_times[{i_tick.mode_switches, 2'b00} +: 4];
                n_cd = (st > 4'd9) ? 4'd9 : st;
                n_last = i_tick.mode_switches;
                n_jdone = 1'b0;
                if (n_bdue && !n_jact) begin
                    n_bdue = 1'b0; n_beep = '0; n_ton = 1'b0;
                end
                if (n_spend) begin
                    n_spend = 1'b0;
                    if (n_jact) begin
                        n_jact = 1'b0; n_nnum = '0; n_notec = '0;
                    end
                    n_ton = 1'b1; n_per = acc_pkg::TONE_START; n_bdue = 1'b0; n_beep = '0;
                    n_sec = 1'b0; n_tick = '0;
                    n_state = S_RUN;
                end
            end
        endcase

        // Result word.
        n_res.oven_state    = (n_state == S_RUN) ? acc_pkg::ST_RUN :
                              (n_state == S_PAUSE) ? acc_pkg::ST_PAUSE : acc_pkg::ST_IDLE;
        n_res.seconds_left  = n_cd;
        n_res.mode_index    = n_mode;
        n_res.power_setting = n_pwr;
        n_res.power_leds    = (n_pwr == 2'd0) ? 3'd4 : (n_pwr == 2'd1) ? 3'd6 : 3'd7;
        n_res.buzzer_on     = n_ton;
        n_res.buzzer_period = n_per;
        n_res.notice_led    = n_nlit;
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= n_res;
        end
    end

    // Controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cd <= 4'd5; r_mode <= '0; r_pwr <= '0; r_last <= '0;
            r_tick <= '0; r_beep <= '0; r_notec <= '0; r_sec <= 1'b0; r_bdue <= 1'b0;
            r_ton <= 1'b0; r_per <= acc_pkg::TONE_START; r_jact <= 1'b0;
            r_jdone <= 1'b0; r_nnum <= '0; r_nlit <= 1'b0; r_ncnt <= '0;
            r_cand <= '0; r_rep <= '0; r_stab[0] <= '0; r_stab[1] <= '0;
            r_spend <= 1'b0; r_ppend <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (step) begin
                r_state <= n_state; r_cd <= n_cd; r_mode <= n_mode; r_pwr <= n_pwr;
                r_last <= n_last; r_tick <= n_tick; r_beep <= n_beep; r_notec <= n_notec;
                r_sec <= n_sec; r_bdue <= n_bdue; r_ton <= n_ton; r_per <= n_per;
                r_jact <= n_jact; r_jdone <= n_jdone; r_nnum <= n_nnum;
                r_nlit <= n_nlit; r_ncnt <= n_ncnt; r_cand <= n_cand; r_rep <= n_rep;
                r_stab <= n_stab; r_spend <= n_spend; r_ppend <= n_ppend;
            end
            if (step) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire
